// ----- hw/rtl/mlbpe_pkg.sv -----
// Shared constants, codes and helpers for the multi-LED blink pattern engine.
package mlbpe_pkg;

  localparam int NUM_LEDS_DEF = 12;
  localparam int TICK_MS_DEF  = 5;

  localparam int MS_W        = 16;  // millisecond fields
  localparam int CNT_W       = 16;  // light/gap/pause counters
  localparam int BURST_CNT_W = 9;
  localparam int BURST_LIM_W = 8;
  localparam int OUT_W       = 12;  // width of the level vector
  localparam int LED_MODE_W  = 3;
  localparam int IN_MODE_W   = 2;
  localparam int IN_IDX_W    = 4;

  // beat kind carried in tuser
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PROG = 1'b1;

  // mode codes of a program beat
  localparam logic [IN_MODE_W-1:0] PM_ON    = 2'd0;
  localparam logic [IN_MODE_W-1:0] PM_OFF   = 2'd1;
  localparam logic [IN_MODE_W-1:0] PM_CYCLE = 2'd2;
  localparam logic [IN_MODE_W-1:0] PM_BURST = 2'd3;

  // stored per-LED mode: program code plus one, zero when never programmed
  localparam logic [LED_MODE_W-1:0] LM_NONE  = 3'd0;
  localparam logic [LED_MODE_W-1:0] LM_ON    = 3'd1;
  localparam logic [LED_MODE_W-1:0] LM_OFF   = 3'd2;
  localparam logic [LED_MODE_W-1:0] LM_CYCLE = 3'd3;
  localparam logic [LED_MODE_W-1:0] LM_BURST = 3'd4;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [BURST_CNT_W-1:0] sat_burst(input logic [BURST_CNT_W-1:0] c);
    return (c == {BURST_CNT_W{1'b1}}) ? c : c + BURST_CNT_W'(1);
  endfunction

endpackage

// ----- hw/rtl/mlbpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mlbpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/multi_led_blink_pattern_engine.sv -----
// Top level of the multi-LED blink pattern engine: per-LED state table and sequencer.
//
//  port group | dir | payload
//  -----------+-----+-----------------------------------------------------------
//  in_        | in  | tuser: kind; tdata: led_num, mode, flash_count, ms x3
//  out_       | out | tdata: led_levels, one beat per tick
//
//  Tick beat: the table is walked one entry per cycle through the RAM read port,
//  writing entry n back while entry n+1 is read.
//  Program beat: read, ST_PDIV for blink modes (the three ms-to-tick divisions
//  share one constant-reciprocal multiplier), then write; a bad index is dropped.
//  Reset clears the per-entry valid bits; an entry never written reads as zero.
//  A finished level vector waits in the output register; input is taken while it
//  waits, and only the end of the next tick stalls on it.
module multi_led_blink_pattern_engine #(
  parameter int NUM_LEDS = mlbpe_pkg::NUM_LEDS_DEF,
  parameter int TICK_MS  = mlbpe_pkg::TICK_MS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] led_num, [5:4] mode, [13:6] flash_count, [29:14] light_ms,
  // [45:30] dark_ms, [61:46] pause_ms, [63:62] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [11:0] led_levels, [15:12] zero
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W = mlbpe_pkg::CNT_W;
  localparam int MS_W  = mlbpe_pkg::MS_W;
  localparam int BC_W  = mlbpe_pkg::BURST_CNT_W;
  localparam int BL_W  = mlbpe_pkg::BURST_LIM_W;
  localparam int OUT_W = mlbpe_pkg::OUT_W;
  localparam int LIM_W = $clog2((2 ** MS_W - 1) / TICK_MS + 1);

  // x / TICK_MS == (x * RECIP) >> DIV_SHIFT exactly for every MS_W-bit x
  localparam int DIV_SHIFT = MS_W + $clog2(TICK_MS);
  localparam int RECIP_W   = MS_W + 1;
  localparam int PROD_W    = MS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PDIV   = 3'd1;
  localparam logic [2:0] ST_PWR    = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_TDRAIN = 3'd4;
  localparam logic [2:0] ST_TOUT   = 3'd5;

  localparam logic [1:0] SEL_LIGHT = 2'd0;
  localparam logic [1:0] SEL_DARK  = 2'd1;
  localparam logic [1:0] SEL_PAUSE = 2'd2;

  typedef struct packed {
    logic [mlbpe_pkg::LED_MODE_W-1:0] mode;
    logic [LIM_W-1:0]                 light_lim;
    logic [LIM_W-1:0]                 gap_lim;
    logic [LIM_W-1:0]                 pause_lim;
    logic [BL_W-1:0]                  burst_lim;
    logic [CNT_W-1:0]                 light_cnt;
    logic [CNT_W-1:0]                 gap_cnt;
    logic [CNT_W-1:0]                 pause_cnt;
    logic [BC_W-1:0]                  burst_cnt;
    logic                             level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // input unpack
  logic                               in_kind;
  logic [mlbpe_pkg::IN_IDX_W-1:0]     in_led_num;
  logic [mlbpe_pkg::IN_MODE_W-1:0]    in_mode;
  logic [BL_W-1:0]                    in_flash_count;
  logic [MS_W-1:0]                    in_light_ms;
  logic [MS_W-1:0]                    in_dark_ms;
  logic [MS_W-1:0]                    in_pause_ms;
  logic                               in_idx_ok;

  assign in_kind        = in_tuser;
  assign in_led_num     = in_tdata[3:0];
  assign in_mode        = in_tdata[5:4];
  assign in_flash_count = in_tdata[13:6];
  assign in_light_ms    = in_tdata[29:14];
  assign in_dark_ms     = in_tdata[45:30];
  assign in_pause_ms    = in_tdata[61:46];
  assign in_idx_ok      = (32'(in_led_num) < NUM_LEDS);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] rd_n_r, rd_n_nxt;
  logic [1:0]       div_sel_r, div_sel_nxt;
  logic             st_v_r, st_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [NUM_LEDS-1:0] valid_r;

  logic [IDX_W-1:0]               st_idx_r;
  logic                           rd_ok_r;
  logic [IDX_W-1:0]               p_idx_r;
  logic [mlbpe_pkg::IN_MODE_W-1:0] p_mode_r;
  logic [BL_W-1:0]                p_fc_r;
  logic [MS_W-1:0]                p_light_ms_r, p_dark_ms_r, p_pause_ms_r;
  logic [LIM_W-1:0]               light_lim_r, gap_lim_r, pause_lim_r;
  logic [OUT_W-1:0]               lv_r, lv_nxt;
  logic [OUT_W-1:0]               out_data_r;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  entry_t cur, tick_e, prog_e;

  logic [MS_W-1:0]   ms_sel;
  logic [PROD_W-1:0] prod;
  logic [LIM_W-1:0]  quot;
  logic [CNT_W-1:0]  gap_lim_m1, pause_lim_m1;

  mlbpe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LEDS)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // entry as read; never-written entries look like reset state
  assign cur = rd_ok_r ? entry_t'(mem_rdata) : '0;

  // shared divider: one ms field per cycle
  always_comb begin
    case (div_sel_r)
      SEL_LIGHT: ms_sel = p_light_ms_r;
      SEL_DARK:  ms_sel = p_dark_ms_r;
      default:   ms_sel = p_pause_ms_r;
    endcase
  end

  assign prod = PROD_W'(ms_sel) * PROD_W'(RECIP);
  assign quot = LIM_W'(prod >> DIV_SHIFT);

  // zero minus one wraps at counter width
  assign gap_lim_m1   = CNT_W'(cur.gap_lim) - CNT_W'(1);
  assign pause_lim_m1 = CNT_W'(cur.pause_lim) - CNT_W'(1);

  // one tick step of the entry under the write stage
  always_comb begin
    tick_e = cur;
    case (cur.mode)
      mlbpe_pkg::LM_ON:  tick_e.level = 1'b1;
      mlbpe_pkg::LM_OFF: tick_e.level = 1'b0;
      mlbpe_pkg::LM_CYCLE: begin
        tick_e.light_cnt = mlbpe_pkg::sat_cnt(cur.light_cnt);
        if (cur.light_cnt < CNT_W'(cur.light_lim)) begin
          tick_e.level   = 1'b1;
          tick_e.gap_cnt = '0;
        end else begin
          tick_e.gap_cnt = mlbpe_pkg::sat_cnt(cur.gap_cnt);
          if (cur.gap_cnt < CNT_W'(cur.gap_lim)) begin
            tick_e.level = 1'b0;
          end else begin
            tick_e.light_cnt = '0;
          end
        end
      end
      mlbpe_pkg::LM_BURST: begin
        if (cur.burst_cnt <= BC_W'(cur.burst_lim)) begin
          tick_e.light_cnt = mlbpe_pkg::sat_cnt(cur.light_cnt);
          if (cur.light_cnt < CNT_W'(cur.light_lim)) begin
            tick_e.level   = 1'b1;
            tick_e.gap_cnt = '0;
          end else begin
            tick_e.gap_cnt = mlbpe_pkg::sat_cnt(cur.gap_cnt);
            if (cur.gap_cnt < gap_lim_m1) begin
              tick_e.level = 1'b0;
            end else begin
              tick_e.light_cnt = '0;
              tick_e.burst_cnt = mlbpe_pkg::sat_burst(cur.burst_cnt);
            end
          end
        end else begin
          tick_e.pause_cnt = mlbpe_pkg::sat_cnt(cur.pause_cnt);
          if (cur.pause_cnt < pause_lim_m1) begin
            tick_e.level = 1'b0;
          end else begin
            tick_e.pause_cnt = '0;
            tick_e.burst_cnt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // program write: steady modes only change the mode, level is kept
  always_comb begin
    prog_e      = cur;
    prog_e.mode = mlbpe_pkg::LED_MODE_W'(p_mode_r) + mlbpe_pkg::LED_MODE_W'(1);
    if (p_mode_r >= mlbpe_pkg::PM_CYCLE) begin
      prog_e.light_cnt = '0;
      prog_e.gap_cnt   = '0;
      prog_e.pause_cnt = '0;
      prog_e.burst_cnt = '0;
      prog_e.light_lim = light_lim_r;
      prog_e.gap_lim   = gap_lim_r;
      if (p_mode_r == mlbpe_pkg::PM_BURST) begin
        prog_e.pause_lim = pause_lim_r;
        prog_e.burst_lim = p_fc_r;
      end else begin
        prog_e.pause_lim = '0;
        prog_e.burst_lim = '0;
      end
    end
  end

  always_comb begin
    lv_nxt = lv_r;
    for (int j = 0; j < OUT_W; j++) begin
      if (32'(st_idx_r) == j) begin
        lv_nxt[j] = tick_e.level;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_n_nxt      = rd_n_r;
    div_sel_nxt   = div_sel_r;
    st_v_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_n_r;
    mem_we        = 1'b0;
    mem_waddr     = st_idx_r;
    mem_wdata     = tick_e;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == mlbpe_pkg::KIND_PROG) begin
            // out-of-range index: beat is dropped
            if (in_idx_ok) begin
              mem_re      = 1'b1;
              mem_raddr   = IDX_W'(in_led_num);
              div_sel_nxt = SEL_LIGHT;
              state_nxt   = (in_mode >= mlbpe_pkg::PM_CYCLE) ? ST_PDIV : ST_PWR;
            end
          end else begin
            rd_n_nxt  = '0;
            state_nxt = ST_TICK;
          end
        end
      end
      ST_PDIV: begin
        div_sel_nxt = div_sel_r + 2'd1;
        if (div_sel_r == SEL_PAUSE) begin
          state_nxt = ST_PWR;
        end
      end
      ST_PWR: begin
        mem_we    = 1'b1;
        mem_waddr = p_idx_r;
        mem_wdata = prog_e;
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        mem_re   = 1'b1;
        st_v_nxt = 1'b1;
        if (rd_n_r == IDX_W'(NUM_LEDS - 1)) begin
          state_nxt = ST_TDRAIN;
        end else begin
          rd_n_nxt = rd_n_r + IDX_W'(1);
        end
      end
      ST_TDRAIN: state_nxt = ST_TOUT;
      ST_TOUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // write stage of the table walk
    if (st_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = st_idx_r;
      mem_wdata = tick_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_n_r      <= '0;
      div_sel_r   <= SEL_LIGHT;
      st_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_n_r      <= rd_n_nxt;
      div_sel_r   <= div_sel_nxt;
      st_v_r      <= st_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      p_idx_r      <= IDX_W'(in_led_num);
      p_mode_r     <= in_mode;
      p_fc_r       <= in_flash_count;
      p_light_ms_r <= in_light_ms;
      p_dark_ms_r  <= in_dark_ms;
      p_pause_ms_r <= in_pause_ms;
      lv_r         <= '0;
    end else if (st_v_r) begin
      lv_r <= lv_nxt;
    end
    if (mem_re) begin
      rd_ok_r  <= valid_r[mem_raddr];
      st_idx_r <= mem_raddr;
    end
    if (state_r == ST_PDIV) begin
      case (div_sel_r)
        SEL_LIGHT: light_lim_r <= quot;
        SEL_DARK:  gap_lim_r   <= quot;
        default:   pause_lim_r <= quot;
      endcase
    end
    if (state_r == ST_TOUT && (!out_valid_r || out_tready)) begin
      out_data_r <= lv_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_data_r);

  // read and write of the walk never hit the same entry in one cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("state RAM read and write to the same entry");

  // the write stage is empty whenever new beats are taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !st_v_r)
    else $error("table walk still writing while idle");

  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (32'(mem_raddr) < NUM_LEDS))
    else $error("state RAM read beyond LED count");

  a_drain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TDRAIN) |=> ((state_r == ST_TOUT) && !st_v_r))
    else $error("tick walk did not finish before output");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the multi-LED blink pattern engine: driver, monitor, predictor.
module tb;

  localparam int LEDS       = mlbpe_pkg::NUM_LEDS_DEF;
  localparam int TICK       = mlbpe_pkg::TICK_MS_DEF;
  localparam int RAND_BEATS = 1750;
  localparam int STALL_MAX  = 2000;

  localparam int IDX_W   = mlbpe_pkg::IN_IDX_W;
  localparam int MODE_W  = mlbpe_pkg::IN_MODE_W;
  localparam int FC_W    = mlbpe_pkg::BURST_LIM_W;
  localparam int MS_W    = mlbpe_pkg::MS_W;
  localparam int CNT_W   = mlbpe_pkg::CNT_W;
  localparam int BC_W    = mlbpe_pkg::BURST_CNT_W;
  localparam int OUT_W   = mlbpe_pkg::OUT_W;
  localparam int LMODE_W = mlbpe_pkg::LED_MODE_W;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [MODE_W-1:0] mode;
    logic [FC_W-1:0]   flashes;
    logic [MS_W-1:0]   light_ms;
    logic [MS_W-1:0]   dark_ms;
    logic [MS_W-1:0]   pause_ms;
    logic              hold_idle;  // wait for all levels before sending
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  beat_t             beats_q[$];
  logic [OUT_W-1:0]  levels_q[$];
  int                errors = 0;
  logic              in_taken = 1'b0;
  bit                hold_next = 1'b0;

  // predicted per-LED state
  logic [LMODE_W-1:0] led_state [LEDS];
  logic [13:0]        lim_light [LEDS];
  logic [13:0]        lim_gap   [LEDS];
  logic [13:0]        lim_pause [LEDS];
  logic [FC_W-1:0]    lim_burst [LEDS];
  logic [CNT_W-1:0]   cnt_light [LEDS];
  logic [CNT_W-1:0]   cnt_gap   [LEDS];
  logic [CNT_W-1:0]   cnt_pause [LEDS];
  logic [BC_W-1:0]    cnt_burst [LEDS];
  logic               lit       [LEDS];

  multi_led_blink_pattern_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int n = 0; n < LEDS; n++) begin
      led_state[n] = mlbpe_pkg::LM_NONE;
      lim_light[n] = '0;
      lim_gap[n]   = '0;
      lim_pause[n] = '0;
      lim_burst[n] = '0;
      cnt_light[n] = '0;
      cnt_gap[n]   = '0;
      cnt_pause[n] = '0;
      cnt_burst[n] = '0;
      lit[n]       = 1'b0;
    end
  end

  function automatic void program_led(beat_t b);
    int n;
    n = int'(b.idx);
    if (n < LEDS) begin
      if (b.mode == mlbpe_pkg::PM_CYCLE || b.mode == mlbpe_pkg::PM_BURST) begin
        cnt_light[n] = '0;
        cnt_gap[n]   = '0;
        cnt_pause[n] = '0;
        cnt_burst[n] = '0;
        lim_light[n] = 14'(b.light_ms / TICK);
        lim_gap[n]   = 14'(b.dark_ms / TICK);
        lim_pause[n] = (b.mode == mlbpe_pkg::PM_BURST) ? 14'(b.pause_ms / TICK) : '0;
        lim_burst[n] = (b.mode == mlbpe_pkg::PM_BURST) ? b.flashes : '0;
      end
      case (b.mode)
        mlbpe_pkg::PM_ON:    led_state[n] = mlbpe_pkg::LM_ON;
        mlbpe_pkg::PM_OFF:   led_state[n] = mlbpe_pkg::LM_OFF;
        mlbpe_pkg::PM_CYCLE: led_state[n] = mlbpe_pkg::LM_CYCLE;
        default:             led_state[n] = mlbpe_pkg::LM_BURST;
      endcase
    end
  endfunction

  // advance every LED by one tick and return the new level vector
  function automatic logic [OUT_W-1:0] advance_patterns();
    logic [OUT_W-1:0] v;
    logic [CNT_W-1:0] old;
    logic [CNT_W-1:0] gap_end;
    logic [CNT_W-1:0] pause_end;
    v = '0;
    for (int n = 0; n < LEDS; n++) begin
      case (led_state[n])
        mlbpe_pkg::LM_ON:  lit[n] = 1'b1;
        mlbpe_pkg::LM_OFF: lit[n] = 1'b0;
        mlbpe_pkg::LM_CYCLE, mlbpe_pkg::LM_BURST: begin
          if (led_state[n] == mlbpe_pkg::LM_BURST &&
              cnt_burst[n] > {1'b0, lim_burst[n]}) begin
            pause_end = CNT_W'(lim_pause[n]) - CNT_W'(1);
            old = cnt_pause[n];
            if (old != '1) cnt_pause[n] = old + CNT_W'(1);
            if (old < pause_end) begin
              lit[n] = 1'b0;
            end else begin
              cnt_pause[n] = '0;
              cnt_burst[n] = '0;
            end
          end else begin
            // burst mode ends each gap one tick early (limit minus one, wraps at zero)
            gap_end = CNT_W'(lim_gap[n]);
            if (led_state[n] == mlbpe_pkg::LM_BURST) gap_end = gap_end - CNT_W'(1);
            old = cnt_light[n];
            if (old != '1) cnt_light[n] = old + CNT_W'(1);
            if (old < CNT_W'(lim_light[n])) begin
              lit[n] = 1'b1;
              cnt_gap[n] = '0;
            end else begin
              old = cnt_gap[n];
              if (old != '1) cnt_gap[n] = old + CNT_W'(1);
              if (old < gap_end) begin
                lit[n] = 1'b0;
              end else begin
                cnt_light[n] = '0;
                if (led_state[n] == mlbpe_pkg::LM_BURST && cnt_burst[n] != '1)
                  cnt_burst[n] = cnt_burst[n] + BC_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
      if (n < OUT_W) v[n] = lit[n];
    end
    return v;
  endfunction

  function automatic void queue_beat(logic kind, logic [IDX_W-1:0] idx,
                                     logic [MODE_W-1:0] mode,
                                     logic [FC_W-1:0] flashes,
                                     logic [MS_W-1:0] light_ms, logic [MS_W-1:0] dark_ms,
                                     logic [MS_W-1:0] pause_ms);
    beat_t b;
    b.kind      = kind;
    b.idx       = idx;
    b.mode      = mode;
    b.flashes   = flashes;
    b.light_ms  = light_ms;
    b.dark_ms   = dark_ms;
    b.pause_ms  = pause_ms;
    b.hold_idle = hold_next;
    hold_next   = 1'b0;
    beats_q.push_back(b);
  endfunction

  // mostly short durations so patterns turn over, sometimes anything
  function automatic logic [MS_W-1:0] pick_ms();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return MS_W'($urandom_range(0, 45));
    if (r == 8) return MS_W'($urandom_range(0, 600));
    return MS_W'($urandom);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH @%0t: %s: got 0x%h, expected 0x%h", $time, what, got, want);
    errors++;
  endtask

  // sender: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : drive
    beat_t b;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (beats_q.size() != 0 &&
                   !(beats_q[0].hold_idle && levels_q.size() != 0)) begin
        b = beats_q[0];
        in_tvalid <= 1'b1;
        in_tuser  <= b.kind;
        in_tdata  <= {2'b00, b.pause_ms, b.dark_ms, b.light_ms, b.flashes, b.mode, b.idx};
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: randomly chosen ready and stall stretches
  int rx_left = 0;

  always @(negedge clk) begin : sink
    if (rx_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        rx_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 6);
      end else begin
        out_tready <= 1'b1;
        rx_left = $urandom_range(1, 40);
      end
    end else begin
      rx_left--;
    end
  end

  always @(posedge clk) begin : monitor
    beat_t b;
    logic [OUT_W-1:0] want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        b = beats_q.pop_front();
        if (b.kind == mlbpe_pkg::KIND_TICK) levels_q.push_back(advance_patterns());
        else program_led(b);
      end
      if (out_tvalid && out_tready) begin
        if (levels_q.size() == 0) begin
          report_mismatch("level beat with none pending", out_tdata, '0);
        end else begin
          want = levels_q.pop_front();
          if (out_tdata[OUT_W-1:0] != want)
            report_mismatch("led_levels", 16'(out_tdata[OUT_W-1:0]), 16'(want));
          if (out_tdata[15:OUT_W] != '0)
            report_mismatch("tdata pad bits", out_tdata, {4'b0, want});
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("multi_led_blink_pattern_engine test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int rand_cnt;
    logic [IDX_W-1:0] idx;

    // directed: untouched LEDs, steady modes, index edges, blink edge cases
    queue_beat(mlbpe_pkg::KIND_TICK, '0, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd0, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd1, mlbpe_pkg::PM_OFF, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd11, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd12, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd15, mlbpe_pkg::PM_BURST, 8'hFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(mlbpe_pkg::KIND_TICK, '0, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd2, mlbpe_pkg::PM_CYCLE, '0, 16'd10, 16'd10, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd3, mlbpe_pkg::PM_BURST, 8'd1,
               16'd5, 16'd10, 16'd15);
    // zero gap and pause limits wrap to the full counter range
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd4, mlbpe_pkg::PM_BURST, 8'd0, 16'd5, 16'd0, 16'd0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd5, mlbpe_pkg::PM_CYCLE, '0, 16'd0, 16'd0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd6, mlbpe_pkg::PM_CYCLE, 8'hFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd7, mlbpe_pkg::PM_BURST, 8'hFF,
               16'd4, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++)
      queue_beat(mlbpe_pkg::KIND_TICK, '0, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd0, mlbpe_pkg::PM_OFF, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_PROG, 4'd1, mlbpe_pkg::PM_ON, '0, '0, '0, '0);
    queue_beat(mlbpe_pkg::KIND_TICK, '0, mlbpe_pkg::PM_ON, '0, '0, '0, '0);

    // random: mostly ticks so patterns run through their phases
    hold_next = 1'b1;
    rand_cnt = 0;
    while (rand_cnt < RAND_BEATS) begin
      if ($urandom_range(0, 249) == 0) hold_next = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        queue_beat(mlbpe_pkg::KIND_TICK, IDX_W'($urandom), MODE_W'($urandom),
                   FC_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                   MS_W'($urandom));
        rand_cnt++;
      end else begin
        idx = ($urandom_range(0, 19) == 0) ? IDX_W'($urandom_range(LEDS, 15))
                                            : IDX_W'($urandom_range(0, LEDS - 1));
        queue_beat(mlbpe_pkg::KIND_PROG, idx, MODE_W'($urandom),
                   ($urandom_range(0, 4) == 0) ? FC_W'($urandom)
                                                : FC_W'($urandom_range(0, 3)),
                   pick_ms(), pick_ms(), pick_ms());
        if (int'(idx) < LEDS) rand_cnt++;
      end
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (beats_q.size() != 0 || levels_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) $display("multi_led_blink_pattern_engine test passed");
    else $display("multi_led_blink_pattern_engine test failed");
    $finish;
  end

endmodule

// ----- multi_led_blink_pattern_engine.f -----
hw/rtl/mlbpe_pkg.sv
hw/rtl/mlbpe_ram.sv
hw/rtl/multi_led_blink_pattern_engine.sv
tb/tb.sv
